/* sv/tad_pkg.sv */
// Shared types, constants and ROM-building functions for the tanh forward/backward block.
package tad_pkg;

	localparam int TABLE_SEGMENTS_DEF = 256;
	localparam int FRAC_BITS_DEF      = 12;

	localparam int X_W = 16;
	localparam int Y_W = 14;
	localparam int G_W = 16;
	localparam int R_W = 16;

	localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;

	typedef enum logic {
		OP_FWD = 1'b0,
		OP_BWD = 1'b1
	} op_t;

	// Restoring long division, used only while building constant tables.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		int i;
		rem = '0;
		quo = '0;
		for (i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// exp(-16/segs) in unsigned Q32, Taylor series truncated after the 20th-power term.
	function automatic logic [63:0] exp_base(input int segs);
		logic [63:0] term;
		longint      sum;
		int n;
		term = ONE_Q32;
		sum  = longint'(ONE_Q32);
		for (n = 1; n <= 20; n++) begin
			term = udiv64(term * 64'd16, 64'(segs) * 64'(n));
			if ((n % 2) == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		if (sum > longint'(ONE_Q32 - 64'd1))
			sum = longint'(ONE_Q32 - 64'd1);
		return 64'(sum);
	endfunction

	// tanh endpoint rounded to frac fraction bits, from p ~ exp(-2x) in Q32.
	function automatic logic [63:0] endpoint(input logic [63:0] p, input int frac);
		logic [63:0] num;
		logic [63:0] den;
		num = (ONE_Q32 - p) * (64'd2 << frac) + (ONE_Q32 + p);
		den = 64'd2 * (ONE_Q32 + p);
		return udiv64(num, den);
	endfunction

endpackage

/* sv/tad_fwd_path.sv */
// Forward datapath: |x| scaling, segment ROM read, interpolation multiply.
module tad_fwd_path #(
	parameter int TABLE_SEGMENTS = tad_pkg::TABLE_SEGMENTS_DEF,
	parameter int FRAC_BITS      = tad_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic [2:0]                       en,
	input  logic signed [tad_pkg::X_W-1:0]   x_value,
	output logic signed [tad_pkg::R_W-1:0]   fwd_result
);

	localparam int EW       = FRAC_BITS + 1;
	localparam int SPAN_LOG = FRAC_BITS + 3;
	localparam int AW       = (SPAN_LOG > tad_pkg::X_W) ? SPAN_LOG : tad_pkg::X_W;
	localparam int IW       = (TABLE_SEGMENTS > 1) ? $clog2(TABLE_SEGMENTS) : 1;
	localparam int POS_W    = SPAN_LOG + IW;
	localparam int PW       = EW + SPAN_LOG;
	localparam int MW       = EW + 1;

	typedef logic [2*EW-1:0] rom_t [TABLE_SEGMENTS];

	// Entry i holds {e_i, e_(i+1) - e_i}.
	function automatic rom_t build_rom();
		rom_t        r;
		logic [63:0] base;
		logic [63:0] p;
		logic [63:0] e_prev;
		logic [63:0] e_cur;
		int k;
		base   = tad_pkg::exp_base(TABLE_SEGMENTS);
		p      = tad_pkg::ONE_Q32;
		e_prev = tad_pkg::endpoint(p, FRAC_BITS);
		for (k = 1; k <= TABLE_SEGMENTS; k++) begin
			p        = (p * base + 64'h8000_0000) >> 32;
			e_cur    = tad_pkg::endpoint(p, FRAC_BITS);
			r[k-1]   = {EW'(e_prev), EW'(e_cur - e_prev)};
			e_prev   = e_cur;
		end
		return r;
	endfunction

	localparam rom_t ROM = build_rom();

	logic [AW-1:0]    a_mag;
	logic             sat_now;
	logic [POS_W-1:0] pos_now;

	logic             neg_s1, sat_s1;
	logic [POS_W-1:0] pos_s1;

	logic             neg_s2, sat_s2;
	logic [EW-1:0]    e_s2, dl_s2;
	logic [SPAN_LOG-1:0] f_s2;
	logic [IW-1:0]    idx;
	logic [2*EW-1:0]  rom_word;

	logic             neg_s3, sat_s3;
	logic [EW-1:0]    e_s3;
	logic [PW-1:0]    prod_s3;

	logic [PW:0]      prod_rnd;
	logic [MW-1:0]    mag;

	always_comb begin
		a_mag   = x_value[tad_pkg::X_W-1] ? AW'(-{1'b1, x_value}) : AW'({1'b0, x_value});
		sat_now = ({1'b0, a_mag} >= (AW+1)'(1) << SPAN_LOG);
		pos_now = POS_W'(a_mag[SPAN_LOG-1:0]) * POS_W'(TABLE_SEGMENTS);
	end

	assign idx      = pos_s1[POS_W-1:SPAN_LOG];
	assign rom_word = ROM[idx];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			neg_s1 <= x_value[tad_pkg::X_W-1];
			sat_s1 <= sat_now;
			pos_s1 <= pos_now;
		end
		if (en[1]) begin
			neg_s2 <= neg_s1;
			sat_s2 <= sat_s1;
			e_s2   <= rom_word[2*EW-1:EW];
			dl_s2  <= rom_word[EW-1:0];
			f_s2   <= pos_s1[SPAN_LOG-1:0];
		end
		if (en[2]) begin
			neg_s3  <= neg_s2;
			sat_s3  <= sat_s2;
			e_s3    <= e_s2;
			prod_s3 <= PW'(dl_s2) * PW'(f_s2);
		end
	end

	always_comb begin
		prod_rnd = {1'b0, prod_s3} + ((PW+1)'(1) << (SPAN_LOG - 1));
		if (sat_s3)
			mag = MW'(1) << FRAC_BITS;
		else
			mag = MW'(e_s3) + MW'(prod_rnd[PW:SPAN_LOG]);
		fwd_result = neg_s3 ? -tad_pkg::R_W'(mag) : tad_pkg::R_W'(mag);
	end

endmodule

/* sv/tad_bwd_path.sv */
// Backward datapath: y*y, 1-y*y in Q(2F), product with dy, round and saturate.
module tad_bwd_path #(
	parameter int FRAC_BITS = tad_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic [2:0]                       en,
	input  logic signed [tad_pkg::Y_W-1:0]   fwd_output,
	input  logic signed [tad_pkg::G_W-1:0]   upstream_grad,
	output logic signed [tad_pkg::R_W-1:0]   bwd_result
);

	localparam int SH   = 2 * FRAC_BITS;
	localparam int YY_W = 2 * tad_pkg::Y_W - 1;
	localparam int DW   = ((SH > YY_W) ? SH : YY_W) + 2;
	localparam int PW   = tad_pkg::G_W + DW;

	logic signed [YY_W-1:0]           yy_full;
	logic [YY_W-1:0]                  yy_s1;
	logic signed [tad_pkg::G_W-1:0]   dy_s1, dy_s2;
	logic signed [DW-1:0]             d_s2;
	logic signed [PW-1:0]             prod_s3;
	logic signed [PW:0]               v_rnd;
	logic signed [PW:0]               r_shift;

	// y*y is never negative and at most 2^26, so YY_W bits hold it as unsigned
	assign yy_full = YY_W'(fwd_output) * YY_W'(fwd_output);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			yy_s1 <= yy_full;
			dy_s1 <= upstream_grad;
		end
		if (en[1]) begin
			d_s2  <= signed'((DW'(1) << SH) - DW'(yy_s1));
			dy_s2 <= dy_s1;
		end
		if (en[2])
			prod_s3 <= PW'(dy_s2) * PW'(d_s2);
	end

	// Arithmetic shift gives floor, which matches round-half-up for both signs.
	always_comb begin
		v_rnd   = (PW+1)'(prod_s3) + ((PW+1)'(1) <<< (SH - 1));
		r_shift = v_rnd >>> SH;
		if (r_shift > (PW+1)'(32767))
			bwd_result = 16'sh7fff;
		else if (r_shift < -(PW+1)'(32768))
			bwd_result = 16'sh8000;
		else
			bwd_result = r_shift[tad_pkg::R_W-1:0];
	end

endmodule

/* sv/tanh_activation_fwd_bwd.sv */
// Top level: tanh forward / derivative backward, four-stage pipeline with output register.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------------------
//  item     | item_valid / item_ready   | operation, x_value, fwd_output, upstream_grad
//  result   | result_valid/result_ready | result
//
// One word per cycle is sustained while result_ready stays high. Three datapath
// stages (scale/square, ROM read/subtract, multiply) feed the result register,
// which does rounding, saturation and sign.
// Reset clears only the stage valid bits. A stall on the result side holds each occupied
// stage with no empty stage after it; the rest advance, so bubbles are squeezed out.
module tanh_activation_fwd_bwd #(
	parameter int TABLE_SEGMENTS = tad_pkg::TABLE_SEGMENTS_DEF,
	parameter int FRAC_BITS      = tad_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  logic                             operation,
	input  logic signed [tad_pkg::X_W-1:0]   x_value,
	input  logic signed [tad_pkg::Y_W-1:0]   fwd_output,
	input  logic signed [tad_pkg::G_W-1:0]   upstream_grad,
	output logic                             result_valid,
	input  logic                             result_ready,
	output logic signed [tad_pkg::R_W-1:0]   result
);

	logic [3:0]  en;
	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	tad_pkg::op_t op_s1, op_s2, op_s3;
	logic signed [tad_pkg::R_W-1:0] result_s4;
	logic signed [tad_pkg::R_W-1:0] fwd_result, bwd_result;

	// A stage loads when it is empty or its contents move on.
	always_comb begin
		en[3] = !valid_s4 || result_ready;
		en[2] = !valid_s3 || en[3];
		en[1] = !valid_s2 || en[2];
		en[0] = !valid_s1 || en[1];
	end

	assign item_ready   = en[0];
	assign result_valid = valid_s4;
	assign result       = result_s4;

	tad_fwd_path #(
		.TABLE_SEGMENTS (TABLE_SEGMENTS),
		.FRAC_BITS      (FRAC_BITS)
	) u_fwd (
		.clk        (clk),
		.en         (en[2:0]),
		.x_value    (x_value),
		.fwd_result (fwd_result)
	);

	tad_bwd_path #(
		.FRAC_BITS (FRAC_BITS)
	) u_bwd (
		.clk           (clk),
		.en            (en[2:0]),
		.fwd_output    (fwd_output),
		.upstream_grad (upstream_grad),
		.bwd_result    (bwd_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en[0])
				valid_s1 <= item_valid;
			if (en[1])
				valid_s2 <= valid_s1;
			if (en[2])
				valid_s3 <= valid_s2;
			if (en[3])
				valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0])
			op_s1 <= tad_pkg::op_t'(operation);
		if (en[1])
			op_s2 <= op_s1;
		if (en[2])
			op_s3 <= op_s2;
		if (en[3])
			result_s4 <= (op_s3 == tad_pkg::OP_BWD) ? bwd_result : fwd_result;
	end

endmodule

/* tb/tanh_checker.sv */
// Watches both channels of the tanh block, predicts each result word and compares it.
module tanh_checker #(
	parameter int TABLE_SEGMENTS = tad_pkg::TABLE_SEGMENTS_DEF,
	parameter int FRAC_BITS      = tad_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	input  logic                           item_ready,
	input  logic                           operation,
	input  logic signed [tad_pkg::X_W-1:0] x_value,
	input  logic signed [tad_pkg::Y_W-1:0] fwd_output,
	input  logic signed [tad_pkg::G_W-1:0] upstream_grad,
	input  logic                           result_valid,
	input  logic                           result_ready,
	input  logic signed [tad_pkg::R_W-1:0] result,
	output int                             err_count,
	output int                             outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_MAX = 10;

	longint tanh_pts [0:TABLE_SEGMENTS];
	logic signed [tad_pkg::R_W-1:0] pending_results [$];
	int result_idx;

	// tanh at x_k = 8k/S, from p_k ~ exp(-2 x_k) built by repeated multiply
	function automatic void build_table();
		logic [63:0] term;
		logic [63:0] decay;
		logic [63:0] p;
		logic [63:0] num;
		logic [63:0] den;
		longint acc;
		int n;
		int k;
		term = tad_pkg::ONE_Q32;
		acc  = longint'(tad_pkg::ONE_Q32);
		for (n = 1; n <= 20; n++) begin
			term = (term * 64'd16) / (64'(TABLE_SEGMENTS) * 64'(n));
			if (n % 2 == 1)
				acc -= longint'(term);
			else
				acc += longint'(term);
		end
		if (acc < 0)
			acc = 0;
		if (acc > longint'(tad_pkg::ONE_Q32 - 64'd1))
			acc = longint'(tad_pkg::ONE_Q32 - 64'd1);
		decay = 64'(acc);
		p = tad_pkg::ONE_Q32;
		for (k = 0; k <= TABLE_SEGMENTS; k++) begin
			if (k > 0)
				p = (p * decay + 64'h8000_0000) >> 32;
			num = (tad_pkg::ONE_Q32 - p) * (64'd2 << FRAC_BITS) + (tad_pkg::ONE_Q32 + p);
			den = 64'd2 * (tad_pkg::ONE_Q32 + p);
			tanh_pts[k] = longint'(num / den);
		end
	endfunction

	function automatic logic signed [tad_pkg::R_W-1:0] tanh_of(
			input logic signed [tad_pkg::X_W-1:0] xv);
		longint xi;
		longint mag;
		longint span;
		longint pos;
		longint seg;
		longint frac;
		longint m;
		xi   = xv;
		mag  = (xi < 0) ? -xi : xi;
		span = longint'(8) << FRAC_BITS;
		if (mag >= span) begin
			m = longint'(1) << FRAC_BITS;
		end else begin
			pos  = mag * TABLE_SEGMENTS;
			seg  = pos / span;
			frac = pos % span;
			if (seg > TABLE_SEGMENTS - 1)
				seg = TABLE_SEGMENTS - 1;
			m = tanh_pts[seg] + ((tanh_pts[seg+1] - tanh_pts[seg]) * frac + span / 2) / span;
		end
		return tad_pkg::R_W'((xi < 0) ? -m : m);
	endfunction

	// dy * (1 - y*y), exact in Q(2F), rounded half up then clamped
	function automatic logic signed [tad_pkg::R_W-1:0] tanh_grad(
			input logic signed [tad_pkg::Y_W-1:0] yv,
			input logic signed [tad_pkg::G_W-1:0] gv);
		longint yi;
		longint gi;
		longint d;
		longint v;
		longint r;
		yi = yv;
		gi = gv;
		d = (longint'(1) << (2 * FRAC_BITS)) - yi * yi;
		v = gi * d + (longint'(1) << (2 * FRAC_BITS - 1));
		r = v >>> (2 * FRAC_BITS);
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return tad_pkg::R_W'(r);
	endfunction

	initial begin
		build_table();
	end

	always @(posedge clk) begin : watch
		logic signed [tad_pkg::R_W-1:0] want;
		if (!arst_n) begin
			pending_results.delete();
			err_count   = 0;
			outstanding = 0;
			result_idx  = 0;
		end else begin
			if (item_valid && item_ready) begin
				if (tad_pkg::op_t'(operation) == tad_pkg::OP_BWD)
					pending_results.push_back(tanh_grad(fwd_output, upstream_grad));
				else
					pending_results.push_back(tanh_of(x_value));
			end
			if (result_valid && result_ready) begin
				if (pending_results.size() == 0) begin
					if (err_count < REPORT_MAX)
						$display("word %0d: unexpected result %0d", result_idx, result);
					err_count++;
				end else begin
					want = pending_results.pop_front();
					if (want !== result) begin
						if (err_count < REPORT_MAX)
							$display("word %0d: result expected %0d got %0d",
								result_idx, want, result);
						err_count++;
					end
				end
				result_idx++;
			end
			outstanding = pending_results.size();
		end
	end

endmodule

/* tb/tb_top.sv */
// Top of the tanh testbench: clock, reset, stimulus, result back-pressure and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_ITEMS = 1750;
	localparam int DRAIN_CYCLES = 20;

	logic                           clk;
	logic                           arst_n;
	logic                           item_valid;
	logic                           item_ready;
	logic                           operation;
	logic signed [tad_pkg::X_W-1:0] x_value;
	logic signed [tad_pkg::Y_W-1:0] fwd_output;
	logic signed [tad_pkg::G_W-1:0] upstream_grad;
	logic                           result_valid;
	logic                           result_ready;
	logic signed [tad_pkg::R_W-1:0] result;
	int                             err_count;
	int                             outstanding;
	int                             cycles;

	tanh_activation_fwd_bwd u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.operation    (operation),
		.x_value      (x_value),
		.fwd_output   (fwd_output),
		.upstream_grad(upstream_grad),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	tanh_checker u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.operation    (operation),
		.x_value      (x_value),
		.fwd_output   (fwd_output),
		.upstream_grad(upstream_grad),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.err_count    (err_count),
		.outstanding  (outstanding)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [tad_pkg::X_W-1:0] pick_x();
		logic signed [tad_pkg::X_W-1:0] v;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: v = 16'sh8000;
					1: v = 16'sh7fff;
					2: v = 16'sh8001;
					default: v = '0;
				endcase
			end
			1, 2: begin
				v = tad_pkg::X_W'($urandom_range(0, 1023));
				if ($urandom_range(0, 1))
					v = -v;
			end
			default: v = tad_pkg::X_W'($urandom());
		endcase
		return v;
	endfunction

	function automatic logic signed [tad_pkg::Y_W-1:0] pick_y();
		logic signed [tad_pkg::Y_W-1:0] v;
		case ($urandom_range(0, 9))
			7, 8: v = tad_pkg::Y_W'($urandom());
			9: begin
				case ($urandom_range(0, 4))
					0: v = 14'sd4096;
					1: v = -14'sd4096;
					2: v = 14'sh1fff;
					3: v = 14'sh2000;
					default: v = '0;
				endcase
			end
			default: v = tad_pkg::Y_W'(int'($urandom_range(0, 8192)) - 4096);
		endcase
		return v;
	endfunction

	function automatic logic signed [tad_pkg::G_W-1:0] pick_grad();
		logic signed [tad_pkg::G_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			1, 2: v = tad_pkg::G_W'(int'($urandom_range(0, 8192)) - 4096);
			default: v = tad_pkg::G_W'($urandom());
		endcase
		return v;
	endfunction

	// present one word and hold it until taken, then optionally drop valid for a gap
	task automatic send_item(input tad_pkg::op_t op, input logic signed [tad_pkg::X_W-1:0] xv,
			input logic signed [tad_pkg::Y_W-1:0] yv,
			input logic signed [tad_pkg::G_W-1:0] gv, input int gap);
		item_valid    <= 1'b1;
		operation     <= op;
		x_value       <= xv;
		fwd_output    <= yv;
		upstream_grad <= gv;
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_fwd(input logic signed [tad_pkg::X_W-1:0] xv);
		send_item(tad_pkg::OP_FWD, xv, tad_pkg::Y_W'($urandom()), tad_pkg::G_W'($urandom()),
			pick_gap());
	endtask

	task automatic send_bwd(input logic signed [tad_pkg::Y_W-1:0] yv,
			input logic signed [tad_pkg::G_W-1:0] gv);
		send_item(tad_pkg::OP_BWD, tad_pkg::X_W'($urandom()), yv, gv, pick_gap());
	endtask

	// result side back-pressure: mostly ready, short stalls, occasional long ones
	initial begin : sink
		int hold;
		int r;
		logic lvl;
		result_ready = 1'b0;
		hold = 0;
		lvl  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold == 0) begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					lvl  = 1'b1;
					hold = $urandom_range(1, 24);
				end else if (r < 60) begin
					lvl  = 1'b1;
					hold = $urandom_range(100, 300);
				end else if (r < 95) begin
					lvl  = 1'b0;
					hold = $urandom_range(1, 3);
				end else begin
					lvl  = 1'b0;
					hold = $urandom_range(15, 60);
				end
			end
			result_ready <= lvl;
			hold--;
		end
	end

	initial begin : stim
		int i;
		int gap;
		logic burst;
		arst_n        = 1'b0;
		item_valid    = 1'b0;
		operation     = tad_pkg::OP_FWD;
		x_value       = '0;
		fwd_output    = '0;
		upstream_grad = '0;
		burst         = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// forward: zero, segment edges, top of table, saturation at -8.0
		send_fwd(16'sd0);
		send_fwd(16'sd1);
		send_fwd(-16'sd1);
		send_fwd(16'sd127);
		send_fwd(16'sd128);
		send_fwd(16'sd4096);
		send_fwd(-16'sd4096);
		send_fwd(16'sd32640);
		send_fwd(16'sh7fff);
		send_fwd(-16'sd32767);
		send_fwd(16'sh8000);
		send_fwd(16'sh5555);
		send_fwd(16'shaaaa);
		// backward: zero slope at |y|=1, |y|>1 negative slope, clamping both ways
		send_bwd(14'sd0, 16'sh7fff);
		send_bwd(14'sd0, 16'sh8000);
		send_bwd(14'sd4096, 16'sd12345);
		send_bwd(-14'sd4096, -16'sd1);
		send_bwd(14'sd2048, 16'sd4096);
		send_bwd(14'sh1fff, 16'sh7fff);
		send_bwd(14'sh2000, 16'sh8000);
		send_bwd(14'sh1fff, 16'sh8000);
		send_bwd(14'sd4097, 16'sd100);
		send_bwd(14'sd1, 16'sd1);
		send_bwd(-14'sd1, -16'sd1);

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 150 == 0)
				burst = ($urandom_range(0, 3) == 0);
			gap = burst ? 0 : pick_gap();
			if ($urandom_range(0, 1))
				send_item(tad_pkg::OP_BWD, tad_pkg::X_W'($urandom()), pick_y(), pick_grad(),
					gap);
			else
				send_item(tad_pkg::OP_FWD, pick_x(), tad_pkg::Y_W'($urandom()),
					tad_pkg::G_W'($urandom()), gap);
		end
		item_valid <= 1'b0;

		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (err_count == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
